### hw/rtl/stp_pkg.sv
`timescale 1ns / 1ps
package stp_pkg;
   localparam int unsigned RAMP_W  = 20;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned SEG_W   = 7;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned SEG_DIVISOR = 10;
   localparam int unsigned SEG_MAX     = 100;
   localparam int signed   NEAR_TOLERANCE = 2;
   localparam logic [RAMP_W-1:0]  OTHER_RAMP = 20'd400;
   localparam logic [SPEED_W-1:0] OTHER_MIN  = 16'd50;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACCEL  = 2'd1,
      PH_CRUISE = 2'd2,
      PH_DECEL  = 2'd3
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RAMP_Z     = 3'd0,
      REG_RAMP_X     = 3'd1,
      REG_RAMP_X_OSC = 3'd2,
      REG_RAMP_B     = 3'd3,
      REG_MIN_Z      = 3'd4,
      REG_MIN_X      = 3'd5,
      REG_MIN_X_OSC  = 3'd6,
      REG_MIN_B      = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         motor;
      logic [POS_W-1:0]   target_position;
      logic [POS_W-1:0]   current_position;
      logic [SPEED_W-1:0] max_speed;
      logic               oscillation_mode;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               segment_valid;
      logic [SEG_W-1:0]   segment_pulses;
      logic               direction;
      logic [SPEED_W-1:0] segment_speed;
      logic               finished;
      logic               busy_res;
   } rsp_type;

   // divider job between sequencer and shared unit
   typedef struct packed {
      logic              start;
      logic [35:0]       dividend;
      logic [RAMP_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [35:0] quotient;
   } div_sts_type;
endpackage

### hw/rtl/stp_if.sv
`timescale 1ns / 1ps
interface stp_req_if;
   logic             valid;
   logic             ready;
   stp_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface stp_rsp_if;
   logic             valid;
   logic             ready;
   stp_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/stepper_trapezoid_segment_planner_core.sv
`timescale 1ns / 1ps
// steps: items with no segment go from evaluation to the output register; a segment also
// passes the phase step, the serial divider for the ramp ratio (ramps only) and emit
// throughput: one transaction at a time; the next is taken once the
// result is handed off or parked in the output register
// reset: synchronous, active high; all motors idle, registers at defaults
module stepper_trapezoid_segment_planner_core #(
   parameter int unsigned NUM_MOTORS = 3
) (
   input  logic clock,
   input  logic reset,
   stp_req_if.sink   req,
   stp_rsp_if.source rsp,
   input  logic                              csr_we,
   input  logic [stp_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [stp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int unsigned MW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int unsigned RW = stp_pkg::RAMP_W;
   localparam int unsigned SW = stp_pkg::SPEED_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HOLD, ST_EVAL, ST_PHASE, ST_DIVIDE, ST_EMIT, ST_OUT
   } state_type;

   state_type state_ff;
   logic [RW-1:0] ramp_ff [4];
   logic [SW-1:0] min_ff  [4];

   logic               moving_ff [NUM_MOTORS];
   stp_pkg::phase_type phase_ff  [NUM_MOTORS];
   logic [31:0]        total_ff  [NUM_MOTORS];
   logic [31:0]        sent_ff   [NUM_MOTORS];
   logic [6:0]         last_ff   [NUM_MOTORS];
   logic               dir_ff    [NUM_MOTORS];
   logic [SW-1:0]      cruise_ff [NUM_MOTORS];
   logic               osc_ff    [NUM_MOTORS];

   stp_pkg::req_type r_ff;
   stp_pkg::rsp_type o_ff;
   logic             ovalid_ff;
   logic [MW-1:0]    m_ff;
   logic [31:0]      rem_ff;
   logic [RW-1:0]    ramp_sel_ff;
   logic [SW-1:0]    min_sel_ff;
   logic [SW-1:0]    spd_ff;
   logic [32:0]      diff_ff;

   stp_pkg::div_cmd_type dcmd;
   stp_pkg::div_sts_type dsts;

   stp_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   // ramp and minimum lookup for a motor and oscillation flag
   function automatic logic [RW-1:0] ramp_lu(input logic [1:0] m, input logic o,
                                             input logic [RW-1:0] r0, input logic [RW-1:0] r1,
                                             input logic [RW-1:0] r2, input logic [RW-1:0] r3);
      logic [RW-1:0] v;
      case (m)
         2'd0:    v = r0;
         2'd1:    v = o ? r2 : r1;
         2'd2:    v = r3;
         default: v = stp_pkg::OTHER_RAMP;
      endcase
      return (v == '0) ? RW'(1) : v;
   endfunction

   function automatic logic [SW-1:0] min_lu(input logic [1:0] m, input logic o,
                                            input logic [SW-1:0] s0, input logic [SW-1:0] s1,
                                            input logic [SW-1:0] s2, input logic [SW-1:0] s3);
      logic [SW-1:0] v;
      case (m)
         2'd0:    v = s0;
         2'd1:    v = o ? s2 : s1;
         2'd2:    v = s3;
         default: v = stp_pkg::OTHER_MIN;
      endcase
      return v;
   endfunction

   logic          cur_osc;
   logic [RW-1:0] cur_ramp;
   logic [SW-1:0] cur_min;
   logic [31:0]   sum_sent;
   logic [31:0]   n_raw;
   logic [RW-1:0] n_clip;
   logic [SW-1:0] span;
   logic [SW-1:0] div_seg;
   logic [6:0]    seg;
   logic          m_ok;

   assign m_ok    = ({2'b00, r_ff.motor} < 4'(NUM_MOTORS));
   assign cur_osc = (r_ff.kind == stp_pkg::KIND_START) ? r_ff.oscillation_mode : osc_ff[m_ff];
   assign cur_ramp = ramp_lu(r_ff.motor, cur_osc, ramp_ff[0], ramp_ff[1], ramp_ff[2], ramp_ff[3]);
   assign cur_min  = min_lu(r_ff.motor, cur_osc, min_ff[0], min_ff[1], min_ff[2], min_ff[3]);
   assign sum_sent = sent_ff[m_ff] + 32'(last_ff[m_ff]);

   always_comb begin
      n_raw = (phase_ff[m_ff] == stp_pkg::PH_ACCEL) ? sent_ff[m_ff]
                                                    : total_ff[m_ff] - sent_ff[m_ff];
      n_clip = (n_raw > 32'(ramp_sel_ff)) ? ramp_sel_ff : n_raw[RW-1:0];
      span   = cruise_ff[m_ff] - min_sel_ff;
      dcmd.start    = 1'b0;
      dcmd.dividend = 36'(span) * 36'(n_clip);
      dcmd.divisor  = ramp_sel_ff;
      if (state_ff == ST_PHASE && phase_ff[m_ff] != stp_pkg::PH_CRUISE
          && cruise_ff[m_ff] >= min_sel_ff)
         dcmd.start = 1'b1;
      // speed / 10 via reciprocal multiply, exact for 16-bit values
      div_seg = SW'((34'(spd_ff) * 34'd52429) >> 19);
      if (div_seg < 16'd1) div_seg = 16'd1;
      if (div_seg > 16'(stp_pkg::SEG_MAX)) div_seg = 16'(stp_pkg::SEG_MAX);
      seg = (32'(div_seg) > rem_ff) ? rem_ff[6:0] : div_seg[6:0];
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ovalid_ff  <= 1'b0;
         ramp_ff[0] <= 20'd6000;
         ramp_ff[1] <= 20'd6000;
         ramp_ff[2] <= 20'd2000;
         ramp_ff[3] <= 20'd400;
         min_ff[0]  <= 16'd100;
         min_ff[1]  <= 16'd100;
         min_ff[2]  <= 16'd200;
         min_ff[3]  <= 16'd100;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            moving_ff[i] <= 1'b0;
            phase_ff[i]  <= stp_pkg::PH_IDLE;
            total_ff[i]  <= '0;
            sent_ff[i]   <= '0;
            last_ff[i]   <= '0;
            dir_ff[i]    <= 1'b0;
            cruise_ff[i] <= '0;
            osc_ff[i]    <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            case (csr_idx)
               stp_pkg::REG_RAMP_Z:     ramp_ff[0] <= csr_wdata;
               stp_pkg::REG_RAMP_X:     ramp_ff[1] <= csr_wdata;
               stp_pkg::REG_RAMP_X_OSC: ramp_ff[2] <= csr_wdata;
               stp_pkg::REG_RAMP_B:     ramp_ff[3] <= csr_wdata;
               stp_pkg::REG_MIN_Z:      min_ff[0]  <= csr_wdata[SW-1:0];
               stp_pkg::REG_MIN_X:      min_ff[1]  <= csr_wdata[SW-1:0];
               stp_pkg::REG_MIN_X_OSC:  min_ff[2]  <= csr_wdata[SW-1:0];
               stp_pkg::REG_MIN_B:      min_ff[3]  <= csr_wdata[SW-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) ovalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  r_ff     <= req.data;
                  m_ff     <= MW'(req.data.motor);
                  diff_ff  <= {req.data.target_position[31], req.data.target_position}
                            - {req.data.current_position[31], req.data.current_position};
                  // hold the new transaction while the previous result still waits
                  state_ff <= (ovalid_ff && !rsp.ready) ? ST_HOLD : ST_EVAL;
               end
            end
            ST_HOLD: begin
               if (!ovalid_ff || rsp.ready) state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               o_ff     <= '0;
               state_ff <= ST_OUT;
               if (m_ok) begin
                  o_ff.busy_res <= moving_ff[m_ff];
                  ramp_sel_ff   <= cur_ramp;
                  min_sel_ff    <= cur_min;
                  case (r_ff.kind)
                     stp_pkg::KIND_START: begin
                        if (!moving_ff[m_ff] && r_ff.max_speed >= cur_min) begin
                           o_ff.accepted <= 1'b1;
                           if ($signed(diff_ff) >= -33'sd2 && $signed(diff_ff) <= 33'sd2) begin
                              o_ff.finished <= 1'b1;
                           end else begin
                              moving_ff[m_ff] <= 1'b1;
                              total_ff[m_ff]  <= diff_ff[32] ? 32'(-diff_ff) : diff_ff[31:0];
                              rem_ff          <= diff_ff[32] ? 32'(-diff_ff) : diff_ff[31:0];
                              sent_ff[m_ff]   <= '0;
                              dir_ff[m_ff]    <= diff_ff[32];
                              cruise_ff[m_ff] <= r_ff.max_speed;
                              osc_ff[m_ff]    <= r_ff.oscillation_mode;
                              phase_ff[m_ff]  <= ((diff_ff[32] ? 32'(-diff_ff) : diff_ff[31:0])
                                                  <= 32'(cur_ramp)) ? stp_pkg::PH_DECEL
                                                                    : stp_pkg::PH_ACCEL;
                              state_ff        <= ST_PHASE;
                           end
                        end
                     end
                     stp_pkg::KIND_DONE: begin
                        if (moving_ff[m_ff]) begin
                           sent_ff[m_ff] <= sum_sent;
                           if (sum_sent >= total_ff[m_ff]) begin
                              moving_ff[m_ff] <= 1'b0;
                              phase_ff[m_ff]  <= stp_pkg::PH_IDLE;
                              osc_ff[m_ff]    <= 1'b0;
                              o_ff.finished   <= 1'b1;
                              o_ff.busy_res   <= 1'b0;
                           end else begin
                              rem_ff <= total_ff[m_ff] - sum_sent;
                              if (phase_ff[m_ff] == stp_pkg::PH_ACCEL
                                  && sum_sent >= 32'(cur_ramp))
                                 phase_ff[m_ff] <= (total_ff[m_ff] - sum_sent <= 32'(cur_ramp))
                                                   ? stp_pkg::PH_DECEL : stp_pkg::PH_CRUISE;
                              else if (phase_ff[m_ff] == stp_pkg::PH_CRUISE
                                       && total_ff[m_ff] - sum_sent <= 32'(cur_ramp))
                                 phase_ff[m_ff] <= stp_pkg::PH_DECEL;
                              state_ff <= ST_PHASE;
                           end
                        end
                     end
                     stp_pkg::KIND_STOP: begin
                        moving_ff[m_ff] <= 1'b0;
                        phase_ff[m_ff]  <= stp_pkg::PH_IDLE;
                        osc_ff[m_ff]    <= 1'b0;
                        o_ff.busy_res   <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_PHASE: begin
               if (phase_ff[m_ff] == stp_pkg::PH_CRUISE) begin
                  spd_ff   <= cruise_ff[m_ff];
                  state_ff <= ST_EMIT;
               end else if (cruise_ff[m_ff] < min_sel_ff) begin
                  spd_ff   <= min_sel_ff;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (dsts.done) begin
                  spd_ff   <= min_sel_ff + dsts.quotient[SW-1:0];
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               last_ff[m_ff]       <= seg;
               o_ff.segment_valid  <= 1'b1;
               o_ff.segment_pulses <= seg;
               o_ff.direction      <= dir_ff[m_ff];
               o_ff.segment_speed  <= spd_ff;
               o_ff.busy_res       <= 1'b1;
               state_ff            <= ST_OUT;
            end
            ST_OUT: begin
               ovalid_ff <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

### hw/rtl/stp_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module stp_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  stp_pkg::div_cmd_type  cmd,
   output stp_pkg::div_sts_type  sts
);
   localparam int unsigned NW = 36;
   localparam int unsigned DW = stp_pkg::RAMP_W;

   logic [NW-1:0]  quo_ff, quo_in;
   logic [DW:0]    rem_ff, rem_in;
   logic [DW-1:0]  den_ff, den_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DW+1:0]  trial;
   logic [DW:0]    shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DW-1:0], quo_ff[NW-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         den_in  = cmd.divisor;
         cnt_in  = 6'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
endmodule
